[rtl/rftp_pkg.sv]
// Shared constants, result codes and queue entry type for the radar frame TLV parser.
`timescale 1ns / 1ps
`default_nettype none
package rftp_pkg;

	// Frame structure
	localparam int MAGIC_BYTES   = 8;
	localparam int HEADER_BYTES  = 40;
	localparam int TLV_HDR_BYTES = 8;
	localparam int LEN_ALIGN_W   = 5;   // total length must be a multiple of 32
	localparam int MAGIC_IDX_W   = $clog2(MAGIC_BYTES);
	localparam int HDR_IDX_W     = $clog2(HEADER_BYTES);
	localparam int TLV_CNT_W     = $clog2(TLV_HDR_BYTES);
	localparam int OFFSET_W      = 34;

	localparam logic [7:0] MAGIC_SEQ [MAGIC_BYTES] = '{
		8'h02, 8'h01, 8'h04, 8'h03, 8'h06, 8'h05, 8'h08, 8'h07
	};

	// Header word slots (byte offset / 4)
	localparam logic [HDR_IDX_W-3:0] WORD_TOTAL = 4'd3;
	localparam logic [HDR_IDX_W-3:0] WORD_PLAT  = 4'd4;
	localparam logic [HDR_IDX_W-3:0] WORD_FRAME = 4'd5;
	localparam logic [HDR_IDX_W-3:0] WORD_NTLV  = 4'd8;

	// Result codes
	localparam logic [1:0] EV_HDR_OK  = 2'd0;
	localparam logic [1:0] EV_HDR_BAD = 2'd1;
	localparam logic [1:0] EV_TLV     = 2'd2;
	localparam logic [1:0] EV_DONE    = 2'd3;

	// Configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_PLATFORM = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN  = 1'd1;
	localparam logic [31:0] MAX_LEN_RESET = 32'd4096;

	// Queue between classifier and emitter
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	// One byte's worth of results: a first result, optionally followed by frame complete
	typedef struct packed {
		logic [1:0]  ev;
		logic        two;
		logic [31:0] frame_number;
		logic [31:0] total_len;
		logic [31:0] tlv_total;
		logic [31:0] tlv_index;
		logic [31:0] tlv_type;
		logic [31:0] tlv_length;
		logic        done_ok;
	} rftp_entry_t;

	// Queue status seen by the two sides
	typedef struct packed {
		logic full;
		logic empty;
	} rftp_qstat_t;

	// Replace one byte lane of a little-endian word
	function automatic logic [31:0] set_lane(logic [31:0] word, logic [1:0] lane,
	                                         logic [7:0] data);
		logic [31:0] res;
		res = word;
		unique case (lane)
			2'd0: res[7:0]   = data;
			2'd1: res[15:8]  = data;
			2'd2: res[23:16] = data;
			default: res[31:24] = data;
		endcase
		return res;
	endfunction

endpackage
`default_nettype wire

[rtl/radar_frame_tlv_parser.sv]
// Top level of the radar frame TLV parser: classifier, entry queue and result emitter.
// Usage:
//   Input channel (in_valid/in_ready/data_byte) takes one received link byte per
//   transfer. The block hunts the magic word, captures and checks the 40-byte header,
//   then walks the TLV headers of the payload.
//   Output channel (out_valid/out_ready and the result fields) gives header accepted,
//   header rejected, TLV header seen and frame complete results; last marks the final
//   result caused by one byte. A byte may give zero, one or two results.
//   Configuration (cfg_we/cfg_index/cfg_data) writes platform_id and max_frame_len;
//   write only while no result is outstanding.
// Timing:
//   One byte per cycle while the queue is not full. On its way out a result is held in
//   the entry queue, which the classifier writes at the byte's transfer edge, and then
//   in the output register, which the emitter loads once the output is free. Results
//   leave at one per cycle while the receiver is ready, so a byte that ends a frame on
//   a TLV header sends its two results one after the other.
// Reset and stall:
//   Reset clears the parser state, sets the registers to their reset values and
//   empties the queue. When the receiver stalls, the output register holds and the
//   four-entry queue fills; in_ready falls only when the queue is full.
`timescale 1ns / 1ps
`default_nettype none
module radar_frame_tlv_parser
	import rftp_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [7:0]           data_byte,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]          cfg_data,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [1:0]                event_res,
	output logic [31:0]               frame_number,
	output logic [31:0]               total_len,
	output logic [31:0]               tlv_total,
	output logic [31:0]               tlv_index,
	output logic [31:0]               tlv_type,
	output logic [31:0]               tlv_length,
	output logic                      frame_ok,
	output logic                      last
);

	rftp_entry_t push_entry, head;
	rftp_qstat_t qstat;
	logic        push, pop;

	rftp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_byte  (data_byte),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.qstat      (qstat),
		.push       (push),
		.push_entry (push_entry)
	);

	rftp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.qstat      (qstat)
	);

	rftp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.qstat        (qstat),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.event_res    (event_res),
		.frame_number (frame_number),
		.total_len    (total_len),
		.tlv_total    (tlv_total),
		.tlv_index    (tlv_index),
		.tlv_type     (tlv_type),
		.tlv_length   (tlv_length),
		.frame_ok     (frame_ok),
		.last         (last)
	);

endmodule
`default_nettype wire

[rtl/rftp_front.sv]
// Front end: magic hunt, header capture and check, TLV walk; builds one queue entry per byte that gives results.
`timescale 1ns / 1ps
`default_nettype none
module rftp_front
	import rftp_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [7:0]           data_byte,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]          cfg_data,
	input  wire rftp_qstat_t          qstat,
	output logic                      push,
	output rftp_entry_t               push_entry
);

	logic [31:0]          platform_q, max_len_q;
	logic [31:0]          pos_q, pos_nx;
	logic [OFFSET_W-1:0]  next_q, next_nx;
	logic [31:0]          acc_q, acc_nx;
	logic                 stop_q, stop_nx;
	logic [63:0]          shift_q, shift_nx;
	logic                 win_q, win_nx;
	logic [TLV_CNT_W-1:0] cnt_q, cnt_nx;
	logic [31:0]          total_q, plat_q, frame_q, ntlv_q;
	logic [31:0]          total_nx, plat_nx, frame_nx, ntlv_nx;

	logic                 fire;
	logic                 in_magic, in_hdr;
	logic [32:0]          pos_inc;
	logic                 hdr_last, hdr_ok;
	logic                 walk_on, take, tlv_end, fits, done;
	logic [31:0]          tlv_len, tlv_typ, acc_inc;
	logic [OFFSET_W-1:0]  tlv_sum;

	assign in_ready = ~qstat.full;
	assign fire     = in_valid & in_ready;
	assign in_magic = pos_q < 32'(MAGIC_BYTES);
	assign in_hdr   = ~in_magic & (pos_q < 32'(HEADER_BYTES));
	assign pos_inc  = {1'b0, pos_q} + 33'd1;
	assign hdr_last = pos_q == 32'(HEADER_BYTES - 1);

	// Header words as they stand after this byte
	always_comb begin
		total_nx = total_q;
		plat_nx  = plat_q;
		frame_nx = frame_q;
		ntlv_nx  = ntlv_q;
		if (in_hdr) begin
			unique case (pos_q[HDR_IDX_W-1:2])
				WORD_TOTAL: total_nx = set_lane(total_q, pos_q[1:0], data_byte);
				WORD_PLAT:  plat_nx  = set_lane(plat_q, pos_q[1:0], data_byte);
				WORD_FRAME: frame_nx = set_lane(frame_q, pos_q[1:0], data_byte);
				WORD_NTLV:  ntlv_nx  = set_lane(ntlv_q, pos_q[1:0], data_byte);
				default: ;
			endcase
		end
	end

	assign hdr_ok = (plat_nx == platform_q) && (total_nx >= 32'(HEADER_BYTES)) &&
	                (total_nx[LEN_ALIGN_W-1:0] == '0) && (total_nx < max_len_q);

	// TLV walk terms
	assign walk_on = ~stop_q & (acc_q < ntlv_q);
	assign take    = walk_on & (win_q | ({{(OFFSET_W-32){1'b0}}, pos_q} == next_q));
	assign tlv_end = take & (cnt_q == TLV_CNT_W'(TLV_HDR_BYTES - 1));
	assign tlv_len = {data_byte, shift_q[63:40]};
	assign tlv_typ = shift_q[39:8];
	assign tlv_sum = next_q + OFFSET_W'(TLV_HDR_BYTES) + {{(OFFSET_W-32){1'b0}}, tlv_len};
	assign fits    = tlv_sum <= {{(OFFSET_W-32){1'b0}}, total_q};
	assign acc_inc = acc_q + 32'd1;
	assign done    = pos_inc >= {1'b0, total_q};

	// Next state and queue entry
	always_comb begin
		pos_nx   = pos_q;
		next_nx  = next_q;
		acc_nx   = acc_q;
		stop_nx  = stop_q;
		shift_nx = shift_q;
		win_nx   = win_q;
		cnt_nx   = cnt_q;
		push     = 1'b0;
		push_entry              = '0;
		push_entry.frame_number = frame_nx;
		push_entry.total_len    = total_nx;
		push_entry.tlv_total    = ntlv_nx;
		if (in_magic) begin
			// hunt: drop a mismatching byte and restart
			if (data_byte == MAGIC_SEQ[pos_q[MAGIC_IDX_W-1:0]]) begin
				pos_nx = pos_inc[31:0];
			end else begin
				pos_nx = '0;
			end
		end else if (in_hdr) begin
			pos_nx = pos_inc[31:0];
			if (hdr_last) begin
				push = 1'b1;
				if (hdr_ok) begin
					push_entry.ev = EV_HDR_OK;
					next_nx  = OFFSET_W'(HEADER_BYTES);
					acc_nx   = '0;
					stop_nx  = 1'b0;
					shift_nx = '0;
					win_nx   = 1'b0;
					cnt_nx   = '0;
				end else begin
					push_entry.ev = EV_HDR_BAD;
					pos_nx = '0;
				end
			end
		end else begin
			stop_nx = ~walk_on;
			if (take) begin
				shift_nx = {data_byte, shift_q[63:8]};
				if (tlv_end) begin
					win_nx = 1'b0;
					cnt_nx = '0;
					if (fits) begin
						acc_nx  = acc_inc;
						next_nx = tlv_sum;
						stop_nx = acc_inc >= ntlv_q;
					end else begin
						stop_nx = 1'b1;
					end
				end else begin
					win_nx = 1'b1;
					cnt_nx = cnt_q + TLV_CNT_W'(1);
				end
			end
			pos_nx = done ? '0 : pos_inc[31:0];
			push_entry.done_ok = acc_nx >= ntlv_q;
			if (tlv_end) begin
				push                  = 1'b1;
				push_entry.ev         = EV_TLV;
				push_entry.two        = done;
				push_entry.tlv_index  = acc_q;
				push_entry.tlv_type   = tlv_typ;
				push_entry.tlv_length = tlv_len;
			end else if (done) begin
				push          = 1'b1;
				push_entry.ev = EV_DONE;
			end
		end
		if (!fire) begin
			push = 1'b0;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			platform_q <= '0;
			max_len_q  <= MAX_LEN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PLATFORM: platform_q <= cfg_data;
				default:      max_len_q  <= cfg_data;
			endcase
		end
	end

	// Parser state: advance on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			next_q  <= OFFSET_W'(HEADER_BYTES);
			acc_q   <= '0;
			stop_q  <= 1'b0;
			shift_q <= '0;
			win_q   <= 1'b0;
			cnt_q   <= '0;
		end else if (fire) begin
			pos_q   <= pos_nx;
			next_q  <= next_nx;
			acc_q   <= acc_nx;
			stop_q  <= stop_nx;
			shift_q <= shift_nx;
			win_q   <= win_nx;
			cnt_q   <= cnt_nx;
		end
	end

	// Header words hold payload only
	always_ff @(posedge clk) begin
		if (fire) begin
			total_q <= total_nx;
			plat_q  <= plat_nx;
			frame_q <= frame_nx;
			ntlv_q  <= ntlv_nx;
		end
	end

endmodule
`default_nettype wire

[rtl/rftp_queue.sv]
// Short entry queue that decouples the classifier from the result emitter.
`timescale 1ns / 1ps
`default_nettype none
module rftp_queue
	import rftp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire rftp_entry_t push_entry,
	input  wire logic        pop,
	output rftp_entry_t      head,
	output rftp_qstat_t      qstat
);

	rftp_entry_t        mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [Q_CNT_W-1:0] count_q;

	assign qstat.full  = count_q == Q_CNT_W'(Q_DEPTH);
	assign qstat.empty = count_q == '0;
	assign head        = mem_q[rd_ptr_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + Q_CNT_W'(1);
				2'b01:   count_q <= count_q - Q_CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= Q_CNT_W'(Q_DEPTH))
		else $error("queue count beyond depth");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !qstat.full)
		else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty)
		else $error("pop from empty queue");
`endif

endmodule
`default_nettype wire

[rtl/rftp_back.sv]
// Back end: expands queue entries into result transfers through an output register.
`timescale 1ns / 1ps
`default_nettype none
module rftp_back
	import rftp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire rftp_entry_t head,
	input  wire rftp_qstat_t qstat,
	output logic             pop,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       event_res,
	output logic [31:0]      frame_number,
	output logic [31:0]      total_len,
	output logic [31:0]      tlv_total,
	output logic [31:0]      tlv_index,
	output logic [31:0]      tlv_type,
	output logic [31:0]      tlv_length,
	output logic             frame_ok,
	output logic             last
);

	logic        out_valid_q;
	logic        second_q;     // first result of head already loaded into the output register
	logic        load, take;
	logic [1:0]  ev_sel;
	logic        ok_sel, last_sel;
	logic [31:0] idx_sel, typ_sel, len_sel;

	assign load = ~out_valid_q | out_ready;
	assign take = load & ~qstat.empty;
	assign pop  = take & (second_q | ~head.two);

	// Pick the result to show from the head entry
	always_comb begin
		if (second_q) begin
			ev_sel   = EV_DONE;
			idx_sel  = '0;
			typ_sel  = '0;
			len_sel  = '0;
			ok_sel   = head.done_ok;
			last_sel = 1'b1;
		end else begin
			ev_sel   = head.ev;
			idx_sel  = head.tlv_index;
			typ_sel  = head.tlv_type;
			len_sel  = head.tlv_length;
			ok_sel   = (head.ev == EV_DONE) & head.done_ok;
			last_sel = ~head.two;
		end
	end

	// Output valid and entry phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			second_q    <= 1'b0;
		end else if (load) begin
			out_valid_q <= ~qstat.empty;
			if (take) begin
				second_q <= ~second_q & head.two;
			end
		end
	end

	// Output payload: hold while stalled
	always_ff @(posedge clk) begin
		if (take) begin
			event_res    <= ev_sel;
			frame_number <= head.frame_number;
			total_len    <= head.total_len;
			tlv_total    <= head.tlv_total;
			tlv_index    <= idx_sel;
			tlv_type     <= typ_sel;
			tlv_length   <= len_sel;
			frame_ok     <= ok_sel;
			last         <= last_sel;
		end
	end

	assign out_valid = out_valid_q;

`ifndef SYNTH
	a_second_needs_pair: assert property (@(posedge clk) disable iff (!arst_n)
		second_q |-> (!qstat.empty && head.two))
		else $error("second result without a paired entry");
	a_second_is_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !last) |-> (event_res == EV_TLV))
		else $error("non-final result that is not a TLV event");
	a_pop_after_first: assert property (@(posedge clk) disable iff (!arst_n)
		(take && !second_q && head.two) |=> second_q)
		else $error("paired entry did not advance to its second result");
`endif

endmodule
`default_nettype wire
